/* design/query_token_scanner_defines.svh */
// Assertion macros used by the checker file of the query token scanner.
`ifndef QUERY_TOKEN_SCANNER_DEFINES_SVH
`define QUERY_TOKEN_SCANNER_DEFINES_SVH

// The antecedent holds, so the consequent holds in the same cycle.
`define QTS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent holds, so the consequent holds in the next cycle.
`define QTS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/qts_pkg.sv */
// Shared types, codes, character constants and helper functions of the query token scanner.
package qts_pkg;

	localparam int POS_WIDTH_DEF = 32;
	localparam int KIND_W        = 5;
	localparam int FIELD_W       = 32;
	localparam int REC_BITS      = KIND_W + 2 * FIELD_W;
	localparam int TDATA_W       = ((REC_BITS + 7) / 8) * 8;
	localparam int QDEPTH        = 4;

	typedef enum logic [KIND_W-1:0] {
		K_EOF        = 5'd0,
		K_ERROR      = 5'd1,
		K_COLON      = 5'd2,
		K_SEMICOLON  = 5'd3,
		K_COMMA      = 5'd4,
		K_DOT        = 5'd5,
		K_STAR       = 5'd6,
		K_UNDERSCORE = 5'd7,
		K_LCURLY     = 5'd8,
		K_RCURLY     = 5'd9,
		K_LPAREN     = 5'd10,
		K_RPAREN     = 5'd11,
		K_EQUAL      = 5'd12,
		K_NOTEQ      = 5'd13,
		K_ANON       = 5'd14,
		K_LBRACKET   = 5'd15,
		K_RBRACKET   = 5'd16,
		K_IRI        = 5'd17,
		K_CHAR       = 5'd18,
		K_STRING     = 5'd19,
		K_VARIABLE   = 5'd20,
		K_IDENT      = 5'd21,
		K_BOOL       = 5'd22
	} kind_t;

	typedef struct packed {
		logic               last;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] start;
		kind_t              kind;
	} rec_t;

	// Keyword matcher states.
	localparam logic [3:0] BM_START = 4'd0;
	localparam logic [3:0] BM_T     = 4'd1;
	localparam logic [3:0] BM_TR    = 4'd2;
	localparam logic [3:0] BM_TRU   = 4'd3;
	localparam logic [3:0] BM_TRUE  = 4'd4;
	localparam logic [3:0] BM_F     = 4'd5;
	localparam logic [3:0] BM_FA    = 4'd6;
	localparam logic [3:0] BM_FAL   = 4'd7;
	localparam logic [3:0] BM_FALS  = 4'd8;
	localparam logic [3:0] BM_FALSE = 4'd9;
	localparam logic [3:0] BM_DEAD  = 4'd15;

	// Character codes.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_QMARK  = 8'h3f;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5a;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_USCORE = 8'h5f;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7a;
	localparam logic [7:0] CH_LCURLY = 8'h7b;
	localparam logic [7:0] CH_RCURLY = 8'h7d;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_L      = 8'h6c;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
			(c == CH_FF);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
			((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	// Advances the case-blind match against "true" and "false" by one byte.
	function automatic logic [3:0] bool_next(input logic [3:0] s, input logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] want;
		lc = ((c >= CH_UA) && (c <= CH_UZ)) ? (c | CASE_BIT) : c;
		want = 8'h00;
		case (s)
			BM_T:    want = CH_R;
			BM_TR:   want = CH_U;
			BM_TRU:  want = CH_E;
			BM_F:    want = CH_A;
			BM_FA:   want = CH_L;
			BM_FAL:  want = CH_S;
			BM_FALS: want = CH_E;
			default: want = 8'h00;
		endcase
		if (s == BM_START) begin
			return (lc == CH_T) ? BM_T : ((lc == CH_F) ? BM_F : BM_DEAD);
		end
		if (want == 8'h00) begin
			return BM_DEAD;
		end
		return (lc == want) ? (s + 4'd1) : BM_DEAD;
	endfunction

endpackage

/* design/query_token_scanner.sv */
// Top level of the query token scanner: streaming lexer from text bytes to token records.
//
// The scanner takes query text one byte per word on the slave side and a closing word with
// s_tuser set, and sends token records on the master side, each giving the token kind, where
// its value starts and how many bytes it spans. A byte is registered in an input stage and
// then classified against the scan mode, its records being written into the output queue, so
// one byte is taken every cycle while that queue has room. Most bytes give no record or
// one; a byte that closes an open token and then starts a new one, or the closing word after
// an open token, gives two. Records leave the four-word queue one per cycle while taken. The
// input stage moves on only while that queue has two free places, so a steady run of
// two-record bytes, or a stalled consumer, slows the slave side to the rate at which words
// leave. Positions count modulo 2**POS_WIDTH and are shown as 32 bits; the closing word
// returns the scanner to idle but keeps the position count.
module query_token_scanner #(
	parameter int POS_WIDTH = qts_pkg::POS_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] char_code
	input  logic                        s_tuser,   // [0] end_of_text
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [qts_pkg::TDATA_W-1:0] m_tdata,   // [4:0] token_kind, [36:5] value_start,
	                                               // [68:37] value_length, rest zero
	output logic                        m_tlast    // last_in_run
);

	localparam int QPTR_W = $clog2(qts_pkg::QDEPTH);
	localparam int QCNT_W = $clog2(qts_pkg::QDEPTH + 1);

	// Scan modes: what the open token is, if any.
	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_GT, M_BANG, M_LT, M_IRI, M_BRACK, M_CHARLIT,
		M_STR, M_STR_ESC, M_VAR, M_IDENT
	} mode_t;

	// Input stage.
	logic                 vld_s1;
	logic [7:0]           char_s1;
	logic                 eot_s1;
	logic                 go_s1;

	// Scanner state.
	mode_t                mode_q, mode_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;
	logic [POS_WIDTH-1:0] start_q, start_d;
	logic [1:0]           lcnt_q, lcnt_d;
	logic [3:0]           bm_q, bm_d;

	// Output queue.
	qts_pkg::rec_t        fifo_q [qts_pkg::QDEPTH];
	logic [QPTR_W-1:0]    wr_q, rd_q;
	logic [QCNT_W-1:0]    cnt_q;

	logic [POS_WIDTH-1:0] p, p1, dl, dl1;

	// Decode of a byte that starts scanning afresh.
	mode_t                st_mode;
	logic                 st_open;
	logic [POS_WIDTH-1:0] st_start;
	logic                 st_emit;
	qts_pkg::kind_t       st_kind;

	// The two candidate records of one byte, in emission order.
	logic                 a_vld, b_vld, again;
	qts_pkg::kind_t       a_kind, b_kind;
	logic [POS_WIDTH-1:0] a_start, a_len, b_start, b_len;
	qts_pkg::kind_t       ident_kind;

	qts_pkg::rec_t        rec0, rec1;
	logic [1:0]           n_push;
	logic                 pop;

	function automatic logic [qts_pkg::FIELD_W-1:0] to_field(input logic [POS_WIDTH-1:0] v);
		logic [POS_WIDTH+qts_pkg::FIELD_W-1:0] ext;
		ext = {{qts_pkg::FIELD_W{1'b0}}, v};
		return ext[qts_pkg::FIELD_W-1:0];
	endfunction

	assign go_s1    = vld_s1 && (cnt_q <= QCNT_W'(qts_pkg::QDEPTH - 2));
	assign s_tready = !vld_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tuser;
		end
	end

	assign p   = pos_q;
	assign p1  = pos_q + POS_WIDTH'(1);
	assign dl  = pos_q - start_q;
	assign dl1 = dl + POS_WIDTH'(1);

	assign ident_kind = ((bm_q == qts_pkg::BM_TRUE) || (bm_q == qts_pkg::BM_FALSE)) ?
		qts_pkg::K_BOOL : qts_pkg::K_IDENT;

	// A byte seen with nothing open: one-byte tokens, openers, blanks and bad bytes.
	always_comb begin
		st_mode  = M_IDLE;
		st_open  = 1'b0;
		st_start = p;
		st_emit  = 1'b0;
		st_kind  = qts_pkg::K_ERROR;
		case (char_s1)
			qts_pkg::CH_HASH:   st_mode = M_COMMENT;
			qts_pkg::CH_COLON:  begin st_emit = 1'b1; st_kind = qts_pkg::K_COLON; end
			qts_pkg::CH_SEMI:   begin st_emit = 1'b1; st_kind = qts_pkg::K_SEMICOLON; end
			qts_pkg::CH_COMMA:  begin st_emit = 1'b1; st_kind = qts_pkg::K_COMMA; end
			qts_pkg::CH_DOT:    begin st_emit = 1'b1; st_kind = qts_pkg::K_DOT; end
			qts_pkg::CH_STAR:   begin st_emit = 1'b1; st_kind = qts_pkg::K_STAR; end
			qts_pkg::CH_USCORE: begin st_emit = 1'b1; st_kind = qts_pkg::K_UNDERSCORE; end
			qts_pkg::CH_LCURLY: begin st_emit = 1'b1; st_kind = qts_pkg::K_LCURLY; end
			qts_pkg::CH_RCURLY: begin st_emit = 1'b1; st_kind = qts_pkg::K_RCURLY; end
			qts_pkg::CH_LPAREN: begin st_emit = 1'b1; st_kind = qts_pkg::K_LPAREN; end
			qts_pkg::CH_RPAREN: begin st_emit = 1'b1; st_kind = qts_pkg::K_RPAREN; end
			qts_pkg::CH_EQ:     begin st_emit = 1'b1; st_kind = qts_pkg::K_EQUAL; end
			qts_pkg::CH_RBRACK: begin st_emit = 1'b1; st_kind = qts_pkg::K_RBRACKET; end
			qts_pkg::CH_GT:     begin st_mode = M_GT;    st_open = 1'b1; end
			qts_pkg::CH_BANG:   begin st_mode = M_BANG;  st_open = 1'b1; end
			qts_pkg::CH_LBRACK: begin st_mode = M_BRACK; st_open = 1'b1; end
			qts_pkg::CH_LT:     begin st_mode = M_LT;    st_open = 1'b1; end
			qts_pkg::CH_SQUOTE: begin
				st_mode  = M_CHARLIT;
				st_open  = 1'b1;
				st_start = p1;
			end
			qts_pkg::CH_DQUOTE: begin
				st_mode  = M_STR;
				st_open  = 1'b1;
				st_start = p1;
			end
			qts_pkg::CH_QMARK, qts_pkg::CH_DOLLAR, qts_pkg::CH_PLUS,
			qts_pkg::CH_MINUS: begin
				st_mode  = M_VAR;
				st_open  = 1'b1;
				st_start = p1;
			end
			default: begin
				if (qts_pkg::is_alnum(char_s1)) begin
					st_mode = M_IDENT;
					st_open = 1'b1;
				end else if (!qts_pkg::is_blank(char_s1)) begin
					st_emit = 1'b1;
				end
			end
		endcase
	end

	// Mode step for one word; the first record closes the open token, the second is the
	// eof record or the token that this byte itself gives.
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		lcnt_d  = lcnt_q;
		bm_d    = bm_q;
		again   = 1'b0;
		a_vld   = 1'b0;
		a_kind  = qts_pkg::K_EOF;
		a_start = start_q;
		a_len   = dl;
		b_vld   = 1'b0;
		b_kind  = qts_pkg::K_EOF;
		b_start = p;
		b_len   = '0;
		if (eot_s1) begin
			mode_d = M_IDLE;
			b_vld  = 1'b1;
			case (mode_q)
				M_GT: begin
					a_vld = 1'b1; a_kind = qts_pkg::K_EQUAL; a_len = POS_WIDTH'(1);
				end
				M_BANG: begin
					a_vld = 1'b1; a_kind = qts_pkg::K_ERROR; a_len = POS_WIDTH'(1);
				end
				M_LT: begin
					a_vld = 1'b1; a_kind = qts_pkg::K_IRI; a_start = p; a_len = '0;
				end
				M_IRI:   begin a_vld = 1'b1; a_kind = qts_pkg::K_IRI; end
				M_BRACK: begin a_vld = 1'b1; a_kind = qts_pkg::K_LBRACKET; end
				M_CHARLIT: begin
					a_vld = 1'b1;
					if (lcnt_q == 2'd1) begin
						a_kind = qts_pkg::K_CHAR;
						a_len  = POS_WIDTH'(1);
					end else begin
						a_kind = qts_pkg::K_ERROR;
					end
				end
				M_STR, M_STR_ESC: begin a_vld = 1'b1; a_kind = qts_pkg::K_STRING; end
				M_VAR:   begin a_vld = 1'b1; a_kind = qts_pkg::K_VARIABLE; end
				M_IDENT: begin a_vld = 1'b1; a_kind = ident_kind; end
				default: a_vld = 1'b0;
			endcase
		end else begin
			pos_d = p1;
			case (mode_q)
				M_COMMENT: begin
					if ((char_s1 == qts_pkg::CH_LF) || (char_s1 == qts_pkg::CH_CR)) begin
						mode_d = M_IDLE;
					end
				end
				M_GT, M_BANG: begin
					a_vld  = 1'b1;
					a_kind = (mode_q == M_GT) ? qts_pkg::K_EQUAL : qts_pkg::K_ERROR;
					a_len  = POS_WIDTH'(1);
					if (char_s1 == qts_pkg::CH_EQ) begin
						a_kind = (mode_q == M_GT) ? qts_pkg::K_EQUAL : qts_pkg::K_NOTEQ;
						a_len  = POS_WIDTH'(2);
						mode_d = M_IDLE;
					end else begin
						again = 1'b1;
					end
				end
				M_LT: begin
					if (char_s1 == qts_pkg::CH_EQ) begin
						a_vld  = 1'b1;
						a_kind = qts_pkg::K_EQUAL;
						a_len  = POS_WIDTH'(2);
						mode_d = M_IDLE;
					end else if (char_s1 == qts_pkg::CH_GT) begin
						a_vld   = 1'b1;
						a_kind  = qts_pkg::K_IRI;
						a_start = p;
						a_len   = '0;
						mode_d  = M_IDLE;
					end else begin
						start_d = p;
						mode_d  = M_IRI;
					end
				end
				M_IRI: begin
					if (char_s1 == qts_pkg::CH_GT) begin
						a_vld  = 1'b1;
						a_kind = qts_pkg::K_IRI;
						mode_d = M_IDLE;
					end
				end
				M_BRACK: begin
					if (char_s1 == qts_pkg::CH_RBRACK) begin
						a_vld  = 1'b1;
						a_kind = qts_pkg::K_ANON;
						a_len  = dl1;
						mode_d = M_IDLE;
					end else if (!qts_pkg::is_blank(char_s1)) begin
						a_vld  = 1'b1;
						a_kind = qts_pkg::K_LBRACKET;
						again  = 1'b1;
					end
				end
				M_CHARLIT: begin
					// The byte right after the opening quote is always part of the literal.
					if (lcnt_q == 2'd0) begin
						lcnt_d = 2'd1;
					end else if (char_s1 == qts_pkg::CH_SQUOTE) begin
						a_vld = 1'b1;
						if (lcnt_q == 2'd1) begin
							a_kind = qts_pkg::K_CHAR;
							a_len  = POS_WIDTH'(1);
							mode_d = M_IDLE;
						end else begin
							a_kind = qts_pkg::K_ERROR;
							again  = 1'b1;
						end
					end else begin
						lcnt_d = 2'd2;
					end
				end
				M_STR: begin
					if (char_s1 == qts_pkg::CH_BSLASH) begin
						mode_d = M_STR_ESC;
					end else if (char_s1 == qts_pkg::CH_DQUOTE) begin
						a_vld  = 1'b1;
						a_kind = qts_pkg::K_STRING;
						mode_d = M_IDLE;
					end
				end
				M_STR_ESC: mode_d = M_STR;
				M_VAR: begin
					if (!qts_pkg::is_alnum(char_s1)) begin
						a_vld  = 1'b1;
						a_kind = qts_pkg::K_VARIABLE;
						again  = 1'b1;
					end
				end
				M_IDENT: begin
					if (qts_pkg::is_alnum(char_s1) || (char_s1 == qts_pkg::CH_USCORE) ||
						(char_s1 == qts_pkg::CH_MINUS) || (char_s1 == qts_pkg::CH_DOT)) begin
						bm_d = qts_pkg::bool_next(bm_q, char_s1);
					end else begin
						a_vld  = 1'b1;
						a_kind = ident_kind;
						again  = 1'b1;
					end
				end
				default: again = 1'b1;
			endcase
			if (again) begin
				mode_d = st_mode;
				if (st_open) begin
					start_d = st_start;
				end
				if (st_mode == M_CHARLIT) begin
					lcnt_d = 2'd0;
				end
				if (st_mode == M_IDENT) begin
					bm_d = qts_pkg::bool_next(qts_pkg::BM_START, char_s1);
				end
				b_vld   = st_emit;
				b_kind  = st_kind;
				b_start = p;
				b_len   = POS_WIDTH'(1);
			end
		end
	end

	// Pack the records of this byte in order; the final one carries last.
	always_comb begin
		rec0.kind  = a_vld ? a_kind : b_kind;
		rec0.start = to_field(a_vld ? a_start : b_start);
		rec0.len   = to_field(a_vld ? a_len : b_len);
		rec0.last  = !(a_vld && b_vld);
		rec1.kind  = b_kind;
		rec1.start = to_field(b_start);
		rec1.len   = to_field(b_len);
		rec1.last  = 1'b1;
		n_push     = go_s1 ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			lcnt_q  <= 2'd0;
			bm_q    <= qts_pkg::BM_START;
		end else if (go_s1) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			lcnt_q  <= lcnt_d;
			bm_q    <= bm_d;
		end
	end

	// Output queue.
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {{(qts_pkg::TDATA_W - qts_pkg::REC_BITS){1'b0}},
		fifo_q[rd_q].len, fifo_q[rd_q].start, fifo_q[rd_q].kind};
	assign m_tlast  = fifo_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_q] <= rec0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_q + QPTR_W'(1)] <= rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_push);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

endmodule

/* design/qts_checker.sv */
// Port-level checker for the query token scanner, bound to its top level.
`include "query_token_scanner_defines.svh"

module qts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [qts_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tlast
);

	logic [qts_pkg::KIND_W-1:0]  kind;
	logic [qts_pkg::FIELD_W-1:0] len;
	logic [qts_pkg::TDATA_W:0]   word;
	logic                        held;
	logic                        is_eof;
	logic                        punct;

	assign kind   = m_tdata[qts_pkg::KIND_W-1:0];
	assign len    = m_tdata[qts_pkg::KIND_W + qts_pkg::FIELD_W +: qts_pkg::FIELD_W];
	assign word   = {m_tlast, m_tdata};
	assign held   = m_tvalid && !m_tready;
	assign is_eof = m_tvalid && (kind == qts_pkg::K_EOF);
	assign punct  = m_tvalid && (kind >= qts_pkg::K_COLON) && (kind <= qts_pkg::K_RPAREN);

	// A word offered and not taken stays on the bus unchanged.
	`QTS_CHECK_NEXT(a_out_hold, held, m_tvalid && $stable(word), "word changed while held")

	// Only defined token kinds leave the block.
	`QTS_CHECK(a_kind_range, m_tvalid, kind <= qts_pkg::K_BOOL, "undefined token kind")

	// The eof record ends its run and has no value bytes.
	`QTS_CHECK(a_eof_shape, is_eof, m_tlast && (len == '0), "malformed eof record")

	// Single-character punctuation always spans exactly one byte.
	`QTS_CHECK(a_punct_len, punct, len == qts_pkg::FIELD_W'(1), "punctuation length not one")

endmodule

bind query_token_scanner qts_checker u_qts_checker (.*);

/* test/query_token_scanner_tb.sv */
// Self-checking testbench of the query token scanner: byte stimulus, token prediction, scoreboard.
module query_token_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qts_pkg::*;

	// Scan modes of the predictor; they mirror the states of the lexer.
	typedef enum logic [3:0] {
		S_IDLE, S_COMMENT, S_GT, S_BANG, S_LT, S_IRI, S_BRACK, S_CHARLIT,
		S_STR, S_STR_ESC, S_VAR, S_IDENT
	} scan_t;

	// Predicts the token records of every accepted word and checks what leaves the block.
	class token_scoreboard;
		rec_t        expected_tokens[$];
		scan_t       mode;
		logic [31:0] pos;
		logic [31:0] tok_start;
		logic [1:0]  lit_cnt;
		logic [3:0]  kw_state;
		int          errors;

		function new();
			mode = S_IDLE;
			pos = '0;
			tok_start = '0;
			lit_cnt = '0;
			kw_state = BM_START;
			errors = 0;
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction

		function void add(kind_t k, logic [31:0] s, logic [31:0] l);
			rec_t r;
			r.kind = k;
			r.start = s;
			r.len = l;
			r.last = 1'b0;
			expected_tokens.push_back(r);
		endfunction

		function logic blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
		endfunction

		function logic word_char(logic [7:0] c);
			return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
				(c >= CH_LA && c <= CH_LZ);
		endfunction

		// Case-blind progress through "true" and "false".
		function logic [3:0] kw_advance(logic [3:0] s, logic [7:0] c);
			logic [7:0] lc;
			lc = (c >= CH_UA && c <= CH_UZ) ? (c ^ CASE_BIT) : c;
			case (s)
				BM_START: return (lc == CH_T) ? BM_T : ((lc == CH_F) ? BM_F : BM_DEAD);
				BM_T:     return (lc == CH_R) ? BM_TR : BM_DEAD;
				BM_TR:    return (lc == CH_U) ? BM_TRU : BM_DEAD;
				BM_TRU:   return (lc == CH_E) ? BM_TRUE : BM_DEAD;
				BM_F:     return (lc == CH_A) ? BM_FA : BM_DEAD;
				BM_FA:    return (lc == CH_L) ? BM_FAL : BM_DEAD;
				BM_FAL:   return (lc == CH_S) ? BM_FALS : BM_DEAD;
				BM_FALS:  return (lc == CH_E) ? BM_FALSE : BM_DEAD;
				default:  return BM_DEAD;
			endcase
		endfunction

		function void close_word(logic [31:0] p);
			add((kw_state == BM_TRUE || kw_state == BM_FALSE) ? K_BOOL : K_IDENT,
				tok_start, p - tok_start);
		endfunction

		// A byte met in idle mode; it is always consumed.
		function void start_token(logic [7:0] c, logic [31:0] p);
			mode = S_IDLE;
			if (blank(c))
				return;
			case (c)
				CH_HASH:   mode = S_COMMENT;
				CH_COLON:  add(K_COLON, p, 1);
				CH_SEMI:   add(K_SEMICOLON, p, 1);
				CH_COMMA:  add(K_COMMA, p, 1);
				CH_DOT:    add(K_DOT, p, 1);
				CH_STAR:   add(K_STAR, p, 1);
				CH_USCORE: add(K_UNDERSCORE, p, 1);
				CH_LCURLY: add(K_LCURLY, p, 1);
				CH_RCURLY: add(K_RCURLY, p, 1);
				CH_LPAREN: add(K_LPAREN, p, 1);
				CH_RPAREN: add(K_RPAREN, p, 1);
				CH_EQ:     add(K_EQUAL, p, 1);
				CH_RBRACK: add(K_RBRACKET, p, 1);
				CH_GT: begin
					tok_start = p;
					mode = S_GT;
				end
				CH_BANG: begin
					tok_start = p;
					mode = S_BANG;
				end
				CH_LBRACK: begin
					tok_start = p;
					mode = S_BRACK;
				end
				CH_LT: begin
					tok_start = p;
					mode = S_LT;
				end
				CH_SQUOTE: begin
					tok_start = p + 1;
					lit_cnt = '0;
					mode = S_CHARLIT;
				end
				CH_DQUOTE: begin
					tok_start = p + 1;
					mode = S_STR;
				end
				CH_QMARK, CH_DOLLAR, CH_PLUS, CH_MINUS: begin
					tok_start = p + 1;
					mode = S_VAR;
				end
				default: begin
					if (word_char(c)) begin
						tok_start = p;
						kw_state = kw_advance(BM_START, c);
						mode = S_IDENT;
					end else begin
						// A byte that cannot open a token is reported and dropped.
						add(K_ERROR, p, 1);
					end
				end
			endcase
		endfunction

		// Text ends while a token is open.
		function void close_at_end(logic [31:0] p);
			case (mode)
				S_GT:      add(K_EQUAL, tok_start, 1);
				S_BANG:    add(K_ERROR, tok_start, 1);
				S_LT:      add(K_IRI, p, 0);
				S_IRI:     add(K_IRI, tok_start, p - tok_start);
				S_BRACK:   add(K_LBRACKET, tok_start, p - tok_start);
				S_CHARLIT: begin
					if (lit_cnt == 2'd1)
						add(K_CHAR, tok_start, 1);
					else
						add(K_ERROR, tok_start, p - tok_start);
				end
				S_STR, S_STR_ESC: add(K_STRING, tok_start, p - tok_start);
				S_VAR:     add(K_VARIABLE, tok_start, p - tok_start);
				S_IDENT:   close_word(p);
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] c, logic eot);
			int          n_prior;
			logic [31:0] p;
			logic        again;
			n_prior = expected_tokens.size();
			p = pos;
			again = 1'b0;
			if (eot) begin
				close_at_end(p);
				add(K_EOF, p, 0);
				mode = S_IDLE;
			end else begin
				case (mode)
					S_COMMENT: begin
						if (c == CH_LF || c == CH_CR)
							mode = S_IDLE;
					end
					S_GT: begin
						if (c == CH_EQ) begin
							add(K_EQUAL, tok_start, 2);
							mode = S_IDLE;
						end else begin
							add(K_EQUAL, tok_start, 1);
							again = 1'b1;
						end
					end
					S_BANG: begin
						if (c == CH_EQ) begin
							add(K_NOTEQ, tok_start, 2);
							mode = S_IDLE;
						end else begin
							add(K_ERROR, tok_start, 1);
							again = 1'b1;
						end
					end
					S_LT: begin
						if (c == CH_EQ) begin
							add(K_EQUAL, tok_start, 2);
							mode = S_IDLE;
						end else if (c == CH_GT) begin
							add(K_IRI, p, 0);
							mode = S_IDLE;
						end else begin
							tok_start = p;
							mode = S_IRI;
						end
					end
					S_IRI: begin
						if (c == CH_GT) begin
							add(K_IRI, tok_start, p - tok_start);
							mode = S_IDLE;
						end
					end
					S_BRACK: begin
						if (c == CH_RBRACK) begin
							add(K_ANON, tok_start, p + 1 - tok_start);
							mode = S_IDLE;
						end else if (!blank(c)) begin
							add(K_LBRACKET, tok_start, p - tok_start);
							again = 1'b1;
						end
					end
					S_CHARLIT: begin
						// The byte right after the opening quote is always part of the literal.
						if (lit_cnt == 2'd0) begin
							lit_cnt = 2'd1;
						end else if (c == CH_SQUOTE) begin
							if (lit_cnt == 2'd1) begin
								add(K_CHAR, tok_start, 1);
								mode = S_IDLE;
							end else begin
								add(K_ERROR, tok_start, p - tok_start);
								again = 1'b1;
							end
						end else begin
							lit_cnt = 2'd2;
						end
					end
					S_STR: begin
						if (c == CH_BSLASH) begin
							mode = S_STR_ESC;
						end else if (c == CH_DQUOTE) begin
							add(K_STRING, tok_start, p - tok_start);
							mode = S_IDLE;
						end
					end
					S_STR_ESC: mode = S_STR;
					S_VAR: begin
						if (!word_char(c)) begin
							add(K_VARIABLE, tok_start, p - tok_start);
							again = 1'b1;
						end
					end
					S_IDENT: begin
						if (word_char(c) || c == CH_USCORE || c == CH_MINUS || c == CH_DOT) begin
							kw_state = kw_advance(kw_state, c);
						end else begin
							close_word(p);
							again = 1'b1;
						end
					end
					default: again = 1'b1;
				endcase
				if (again)
					start_token(c, p);
				pos = p + 1;
			end
			if (expected_tokens.size() > n_prior)
				expected_tokens[expected_tokens.size() - 1].last = 1'b1;
		endfunction

		function void check_token(logic [TDATA_W-1:0] data, logic last);
			rec_t exp_tok;
			rec_t got;
			got.kind = kind_t'(data[KIND_W-1:0]);
			got.start = data[KIND_W +: FIELD_W];
			got.len = data[KIND_W + FIELD_W +: FIELD_W];
			got.last = last;
			if (expected_tokens.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected token kind %0d start %0d len %0d last %0b",
						$realtime, got.kind, got.start, got.len, got.last);
				return;
			end
			exp_tok = expected_tokens.pop_front();
			if (got.kind !== exp_tok.kind || got.start !== exp_tok.start ||
				got.len !== exp_tok.len || got.last !== exp_tok.last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: token mismatch, expected kind %0d start %0d len %0d last %0b, %s",
						$realtime, exp_tok.kind, exp_tok.start, exp_tok.len, exp_tok.last,
						$sformatf("got kind %0d start %0d len %0d last %0b",
							got.kind, got.start, got.len, got.last));
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;

	token_scoreboard sb = new();
	logic            quiet = 1'b0;
	int              sent = 0;

	query_token_scanner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one word after a random gap and holds it until the scanner takes it.
	task automatic send_word(input logic [7:0] c, input logic eot);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= eot;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(c, eot);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	// The end word carries a random byte, which the scanner must ignore.
	task automatic send_end();
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] pick_alnum();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return 8'(CH_0 + r);
		if (r < 36)
			return 8'(CH_UA + r - 10);
		return 8'(CH_LA + r - 36);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_LF;
			3:       return CH_CR;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] pick_punct();
		case ($urandom_range(0, 11))
			0:       return CH_COLON;
			1:       return CH_SEMI;
			2:       return CH_COMMA;
			3:       return CH_DOT;
			4:       return CH_STAR;
			5:       return CH_USCORE;
			6:       return CH_LCURLY;
			7:       return CH_RCURLY;
			8:       return CH_LPAREN;
			9:       return CH_RPAREN;
			10:      return CH_EQ;
			default: return CH_RBRACK;
		endcase
	endfunction

	// Sends one mostly well-formed piece of query text; some pieces are broken on purpose.
	task automatic send_phrase();
		string kw;
		int    n;
		case ($urandom_range(0, 15))
			0: begin
				n = $urandom_range(1, 3);
				repeat (n) send_word(pick_blank(), 1'b0);
			end
			1: begin
				send_word(CH_HASH, 1'b0);
				n = $urandom_range(0, 5);
				repeat (n) send_word(8'($urandom_range(32, 126)), 1'b0);
				send_word($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
			end
			2: send_word(pick_punct(), 1'b0);
			3: begin
				// Comparison operators, with and without the trailing '='.
				case ($urandom_range(0, 2))
					0:       send_word(CH_GT, 1'b0);
					1:       send_word(CH_LT, 1'b0);
					default: send_word(CH_BANG, 1'b0);
				endcase
				if ($urandom_range(0, 2) != 0)
					send_word(CH_EQ, 1'b0);
			end
			4: begin
				send_word(CH_LBRACK, 1'b0);
				n = $urandom_range(0, 3);
				repeat (n) send_word(pick_blank(), 1'b0);
				if ($urandom_range(0, 3) != 0)
					send_word(CH_RBRACK, 1'b0);
			end
			5: begin
				send_word(CH_LT, 1'b0);
				n = $urandom_range(0, 6);
				repeat (n) send_word($urandom_range(0, 3) == 0 ? CH_COLON : pick_alnum(), 1'b0);
				send_word(CH_GT, 1'b0);
			end
			6: begin
				// Character literal: one byte of any value, sometimes too many.
				send_word(CH_SQUOTE, 1'b0);
				send_word(8'($urandom_range(0, 255)), 1'b0);
				if ($urandom_range(0, 2) == 0) begin
					n = $urandom_range(1, 2);
					repeat (n) send_word(pick_alnum(), 1'b0);
				end
				if ($urandom_range(0, 4) != 0)
					send_word(CH_SQUOTE, 1'b0);
			end
			7: begin
				send_word(CH_DQUOTE, 1'b0);
				n = $urandom_range(0, 5);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: begin
							send_word(CH_BSLASH, 1'b0);
							send_word($urandom_range(0, 1) ? CH_DQUOTE : pick_alnum(), 1'b0);
						end
						1:       send_word(pick_blank(), 1'b0);
						default: send_word(pick_alnum(), 1'b0);
					endcase
				end
				if ($urandom_range(0, 4) != 0)
					send_word(CH_DQUOTE, 1'b0);
			end
			8: begin
				case ($urandom_range(0, 3))
					0:       send_word(CH_QMARK, 1'b0);
					1:       send_word(CH_DOLLAR, 1'b0);
					2:       send_word(CH_PLUS, 1'b0);
					default: send_word(CH_MINUS, 1'b0);
				endcase
				n = $urandom_range(0, 4);
				repeat (n) send_word(pick_alnum(), 1'b0);
			end
			9, 10: begin
				// Keywords in random letter case, now and then spoiled by a tail.
				if ($urandom_range(0, 1))
					kw = "true";
				else
					kw = "false";
				for (int i = 0; i < kw.len(); i++)
					send_word($urandom_range(0, 1) ? (kw[i] ^ CASE_BIT) : kw[i], 1'b0);
				if ($urandom_range(0, 3) == 0)
					send_word($urandom_range(0, 1) ? CH_MINUS : pick_alnum(), 1'b0);
			end
			11: begin
				send_word(pick_alnum(), 1'b0);
				n = $urandom_range(0, 4);
				repeat (n) begin
					case ($urandom_range(0, 5))
						0:       send_word(CH_USCORE, 1'b0);
						1:       send_word(CH_DOT, 1'b0);
						2:       send_word(CH_MINUS, 1'b0);
						default: send_word(pick_alnum(), 1'b0);
					endcase
				end
			end
			12, 13: send_word(8'($urandom_range(0, 255)), 1'b0);
			14:     send_end();
			default: send_word(CH_SPACE, 1'b0);
		endcase
	endtask

	// Result side: a random stall before each word, then take it and check it.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_token(m_tdata, m_tlast);
		end
	end

	initial begin
		logic drained;
		drained = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text: char literal, noteq, '>' closed by '[', anon with a blank,
		// bad bytes at both ends of the range, empty iri, keyword in capitals at the end.
		send_text("'a'!=>[ ]");
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		send_text("<>TRUE");
		send_end();
		// An overlong char literal whose closing quote opens a new one.
		send_text("'ab'");
		send_end();
		// An escaped quote inside a string left open at the end.
		send_text("\"\\\"");
		send_end();
		// A char literal cut off after its one byte.
		send_text("'x");
		send_end();

		while (sent < 450) begin
			quiet = (sent >= 180 && sent < 260);
			if (!drained && sent >= 320) begin
				// Let every pending token drain before going on.
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
				drained = 1'b1;
			end
			send_phrase();
		end
		send_end();
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
